// ===== rtl/core/varint_delta_coordinate_decoder_unit_assert.svh =====
// Assertion macros for the checker file of the coordinate decoder.
`ifndef VARINT_DELTA_COORDINATE_DECODER_UNIT_ASSERT_SVH
`define VARINT_DELTA_COORDINATE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define VDCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vdcd assertion failed");

// Next-cycle implication, disabled while rst is high.
`define VDCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vdcd assertion failed");

`endif

// ===== rtl/core/vdcd_pkg.sv =====
// Package with the item types, register indexes and constants of the coordinate decoder.
`default_nettype none
package vdcd_pkg;

   localparam int unsigned SHIFT_W = 6;

   localparam logic [7:0] CONT_MASK  = 8'h80;
   localparam logic [7:0] SIGN_MASK  = 8'h40;
   localparam logic [6:0] GROUP_MASK = 7'h7F;
   localparam logic [6:0] LAST_MASK  = 7'h3F;

   localparam logic [31:0] MAG_ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] NEG_LIMIT    = 32'h8000_0000;
   localparam logic [31:0] POS_LIMIT    = 32'h7FFF_FFFF;

   typedef enum logic {
      CSR_ORIGIN_LAT = 1'b0,
      CSR_ORIGIN_LON = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       list_start;
      logic       double_delta;
   } req_type;

   typedef struct packed {
      logic signed [31:0] node_lat;
      logic signed [31:0] node_lon;
      logic               decode_error;
   } rsp_type;

   typedef struct packed {
      logic               done;
      logic               error;
      logic signed [31:0] value;
   } vint_event_type;

endpackage
`default_nettype wire

// ===== rtl/core/vdcd_varint.sv =====
// Varint assembler: gathers the 7-bit groups of one signed varint and reports its value.
`default_nettype none
module vdcd_varint #(
   parameter int MAX_VARINT_BYTES = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic                    discard,
   input  wire logic                    list_start,
   input  wire logic [7:0]              data_byte,
   output vdcd_pkg::vint_event_type     vint_event
);
   import vdcd_pkg::*;

   localparam logic [SHIFT_W-1:0] LAST_SHIFT = SHIFT_W'(7 * (MAX_VARINT_BYTES - 1));
   localparam logic [SHIFT_W-1:0] GROUP_BITS = SHIFT_W'(7);

   logic [31:0]        partial_ff, partial_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;

   logic [31:0]        part_cur;
   logic [SHIFT_W-1:0] shift_cur;
   logic [31:0]        merged;
   logic [6:0]         group;

   function automatic logic [31:0] merge_bits(input logic [31:0] part,
                                              input logic [SHIFT_W-1:0] sh,
                                              input logic [6:0] bits);
      logic [38:0] wide;
      wide = {32'd0, bits} << sh[4:0];
      if (bits == 7'd0) begin
         return part;
      end
      if (sh >= SHIFT_W'(32)) begin
         return MAG_ALL_ONES;
      end
      if (wide[38:32] != 7'd0) begin
         return MAG_ALL_ONES;
      end
      return part | wide[31:0];
   endfunction

   always_comb begin
      part_cur  = list_start ? 32'd0 : partial_ff;
      shift_cur = list_start ? '0 : shift_ff;
      group     = (data_byte[7] ? GROUP_MASK : LAST_MASK) & data_byte[6:0];
      merged    = merge_bits(part_cur, shift_cur, group);

      partial_in       = part_cur;
      shift_in         = shift_cur;
      vint_event.done  = 1'b0;
      vint_event.error = 1'b0;
      vint_event.value = '0;

      if (!discard) begin
         if ((data_byte & CONT_MASK) != 8'd0) begin
            if (shift_cur >= LAST_SHIFT) begin
               vint_event.error = step;
               partial_in       = 32'd0;
               shift_in         = '0;
            end else begin
               partial_in = merged;
               shift_in   = shift_cur + GROUP_BITS;
            end
         end else begin
            vint_event.done = step;
            partial_in      = 32'd0;
            shift_in        = '0;
            if ((data_byte & SIGN_MASK) != 8'd0) begin
               vint_event.value = (merged > NEG_LIMIT) ? NEG_LIMIT : (32'd0 - merged);
            end else begin
               vint_event.value = merged[31] ? POS_LIMIT : merged;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 32'd0;
         shift_ff   <= '0;
      end else if (step) begin
         partial_ff <= partial_in;
         shift_ff   <= shift_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/varint_delta_coordinate_decoder_unit.sv =====
// Top level of the signed varint delta coordinate decoder.
//
// The req channel carries one byte item of an encoded way-node list per cycle
// unless stalled, with list_start on the first byte of a list and double_delta
// giving the coding mode. The rsp channel gives one coordinate pair in
// microdegrees each time a latitude and a longitude varint have both completed,
// or one item with decode_error set when a varint runs past MAX_VARINT_BYTES
// bytes; the rest of that list is then dropped until the next list_start.
// The csr port writes the tile origin registers; csr_ready is always high.
// An accepted byte sits in the input register and is decoded from there, and
// the varint assembly and saturating adders write the result register, which
// drives rsp, when the byte advances. Throughput is one byte per cycle while
// no result waits under rsp_stall, set by the single pass from the input
// register to the result register.
// A synchronous reset clears the decode state, the origins and both valid
// registers. While the result waits under rsp_stall, one further byte still
// enters the input register; req_stall then stays high while that byte and the
// waiting result are both held, whether or not the byte completes a node.
`default_nettype none
module varint_delta_coordinate_decoder_unit #(
   parameter int MAX_VARINT_BYTES = 5,
   parameter int COORD_WIDTH      = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire vdcd_pkg::req_type       req_data,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output vdcd_pkg::rsp_type            rsp_data,
   input  wire logic                    csr_valid,
   output      logic                    csr_ready,
   input  wire vdcd_pkg::csr_index_type csr_index,
   input  wire logic [28:0]             csr_wdata
);
   import vdcd_pkg::*;

   localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
   localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (SAT_W - 1)) - 34'sd1;
   localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

   logic               in_valid_ff;
   req_type            in_ff;
   logic               advance;

   logic signed [27:0] origin_lat_ff;
   logic signed [28:0] origin_lon_ff;

   logic               lat_ready_ff, lat_ready_in;
   logic signed [31:0] pending_ff, pending_in;
   logic signed [31:0] lat_pos_ff, lat_pos_in;
   logic signed [31:0] lon_pos_ff, lon_pos_in;
   logic signed [31:0] prev_lat_ff, prev_lat_in;
   logic signed [31:0] prev_lon_ff, prev_lon_in;
   logic               first_ff, first_in;
   logic               discarding_ff, discarding_in;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               has_result;

   logic               start;
   logic               discard_cur;
   vint_event_type     vint_event;
   logic signed [31:0] dd_lat, dd_lon;

   function automatic logic signed [31:0] sat_sum(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [33:0] sum;
      sum = {{2{a[31]}}, a} + {{2{b[31]}}, b};
      if (sum > SAT_HI) begin
         return SAT_HI[31:0];
      end
      if (sum < SAT_LO) begin
         return SAT_LO[31:0];
      end
      return sum[31:0];
   endfunction

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   assign start       = in_ff.list_start;
   assign discard_cur = discarding_ff && !start;

   vdcd_varint #(
      .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
   ) u_varint (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .discard    (discard_cur),
      .list_start (start),
      .data_byte  (in_ff.data_byte),
      .vint_event (vint_event)
   );

   always_comb begin
      lat_ready_in  = start ? 1'b0 : lat_ready_ff;
      pending_in    = start ? 32'sd0 : pending_ff;
      prev_lat_in   = start ? 32'sd0 : prev_lat_ff;
      prev_lon_in   = start ? 32'sd0 : prev_lon_ff;
      first_in      = start ? 1'b1 : first_ff;
      discarding_in = discard_cur;
      lat_pos_in    = lat_pos_ff;
      lon_pos_in    = lon_pos_ff;
      has_result    = 1'b0;
      rsp_data_in   = '0;

      dd_lat = sat_sum(prev_lat_in, pending_in);
      dd_lon = sat_sum(prev_lon_in, vint_event.value);

      if (vint_event.error) begin
         discarding_in            = 1'b1;
         lat_ready_in             = 1'b0;
         has_result               = 1'b1;
         rsp_data_in.decode_error = 1'b1;
      end else if (vint_event.done) begin
         if (!lat_ready_in) begin
            pending_in   = vint_event.value;
            lat_ready_in = 1'b1;
         end else begin
            lat_ready_in = 1'b0;
            has_result   = 1'b1;
            if (first_in) begin
               lat_pos_in  = sat_sum({{4{origin_lat_ff[27]}}, origin_lat_ff}, pending_in);
               lon_pos_in  = sat_sum({{3{origin_lon_ff[28]}}, origin_lon_ff},
                                     vint_event.value);
               prev_lat_in = 32'sd0;
               prev_lon_in = 32'sd0;
               first_in    = 1'b0;
            end else if (in_ff.double_delta) begin
               prev_lat_in = dd_lat;
               prev_lon_in = dd_lon;
               lat_pos_in  = sat_sum(lat_pos_ff, dd_lat);
               lon_pos_in  = sat_sum(lon_pos_ff, dd_lon);
            end else begin
               lat_pos_in = sat_sum(lat_pos_ff, pending_in);
               lon_pos_in = sat_sum(lon_pos_ff, vint_event.value);
            end
            rsp_data_in.node_lat = lat_pos_in;
            rsp_data_in.node_lon = lon_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_lat_ff <= '0;
         origin_lon_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORIGIN_LAT: origin_lat_ff <= csr_wdata[27:0];
            CSR_ORIGIN_LON: origin_lon_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ready_ff  <= 1'b0;
         pending_ff    <= '0;
         lat_pos_ff    <= '0;
         lon_pos_ff    <= '0;
         prev_lat_ff   <= '0;
         prev_lon_ff   <= '0;
         first_ff      <= 1'b1;
         discarding_ff <= 1'b0;
      end else if (advance) begin
         lat_ready_ff  <= lat_ready_in;
         pending_ff    <= pending_in;
         lat_pos_ff    <= lat_pos_in;
         lon_pos_ff    <= lon_pos_in;
         prev_lat_ff   <= prev_lat_in;
         prev_lon_ff   <= prev_lon_in;
         first_ff      <= first_in;
         discarding_ff <= discarding_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/vdcd_checker.sv =====
// Port-level checker for the coordinate decoder and its bind to the top level.
`default_nettype none
`include "varint_delta_coordinate_decoder_unit_assert.svh"
module vdcd_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire vdcd_pkg::req_type       req_data,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire vdcd_pkg::rsp_type       rsp_data,
   input wire logic                    csr_valid,
   input wire logic                    csr_ready,
   input wire vdcd_pkg::csr_index_type csr_index,
   input wire logic [28:0]             csr_wdata
);
   import vdcd_pkg::*;

   `VDCD_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))
   `VDCD_ASSERT_NOW(a_error_zero, clock, reset, rsp_valid && rsp_data.decode_error,
      (rsp_data.node_lat == 32'sd0) && (rsp_data.node_lon == 32'sd0))
   `VDCD_ASSERT_NOW(a_reset_clears, clock, 1'b0, $past(reset), !rsp_valid)
   `VDCD_ASSERT_NOW(a_rsp_needs_item, clock, reset, $rose(rsp_valid),
      $past(req_valid && !req_stall, 2))

endmodule

bind varint_delta_coordinate_decoder_unit vdcd_checker u_vdcd_checker (.*);
`default_nettype wire
